>>> hw/rtl/sgr_pkg.sv
// shared types and constants for the sgr stream parser
package sgr_pkg;

  // most result words one input byte can cause
  localparam int MAX_RESULTS = 4;
  // width of a result word count, holds 0..MAX_RESULTS
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // character attributes in force
  typedef struct packed {
    logic [1:0] weight;
    logic       italic_on;
    logic       underline_on;
    logic       strike_on;
    logic       fg_valid;
    logic [3:0] fg_index;
    logic       bg_valid;
    logic [3:0] bg_index;
  } attr_t;

  // what one parsed byte sends to the output stage
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       char_code;
  } emit_t;

endpackage

>>> hw/rtl/sgr_if.sv
// valid/ready channel interfaces for input bytes and result words

// input byte channel
interface sgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// result word channel
interface sgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] weight;
  logic       italic_on;
  logic       underline_on;
  logic       strike_on;
  logic       fg_valid;
  logic [3:0] fg_index;
  logic       bg_valid;
  logic [3:0] bg_index;
  logic       last_of_run;

  modport source (
    output valid, output char_code, output weight, output italic_on,
    output underline_on, output strike_on, output fg_valid, output fg_index,
    output bg_valid, output bg_index, output last_of_run, input ready
  );
  modport sink (
    input valid, input char_code, input weight, input italic_on,
    input underline_on, input strike_on, input fg_valid, input fg_index,
    input bg_valid, input bg_index, input last_of_run, output ready
  );
endinterface

>>> hw/rtl/sgr_parse.sv
// escape sequence parser state and sgr attribute tracking
module sgr_parse #(
  parameter int TAB_SPACES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     byte_in,
  output sgr_pkg::emit_t emit,
  output sgr_pkg::attr_t active
);

  // byte codes
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;

  // sgr codes
  localparam logic [7:0] SGR_RESET      = 8'd0;
  localparam logic [7:0] SGR_BOLD       = 8'd1;
  localparam logic [7:0] SGR_LIGHT      = 8'd2;
  localparam logic [7:0] SGR_ITALIC     = 8'd3;
  localparam logic [7:0] SGR_UNDER      = 8'd4;
  localparam logic [7:0] SGR_SWAP       = 8'd7;
  localparam logic [7:0] SGR_STRIKE     = 8'd9;
  localparam logic [7:0] SGR_NORMAL     = 8'd22;
  localparam logic [7:0] SGR_NO_ITALIC  = 8'd23;
  localparam logic [7:0] SGR_NO_UNDER   = 8'd24;
  localparam logic [7:0] SGR_NO_STRIKE  = 8'd29;
  localparam logic [7:0] SGR_FG_LO      = 8'd30;
  localparam logic [7:0] SGR_FG_HI      = 8'd37;
  localparam logic [7:0] SGR_BG_LO      = 8'd40;
  localparam logic [7:0] SGR_BG_HI      = 8'd47;
  localparam logic [7:0] SGR_FGB_LO     = 8'd90;
  localparam logic [7:0] SGR_FGB_HI     = 8'd97;
  localparam logic [7:0] SGR_BGB_LO     = 8'd100;
  localparam logic [7:0] SGR_BGB_HI     = 8'd107;
  // bright codes map to index 8..15
  localparam logic [7:0] SGR_FGB_BASE   = 8'd82;
  localparam logic [7:0] SGR_BGB_BASE   = 8'd92;

  // weight values
  localparam logic [1:0] WT_NORMAL = 2'd0;
  localparam logic [1:0] WT_BOLD   = 2'd1;
  localparam logic [1:0] WT_LIGHT  = 2'd2;

  // spaces per tab, capped at the result limit
  localparam int TAB_CAP = (TAB_SPACES > sgr_pkg::MAX_RESULTS) ?
                           sgr_pkg::MAX_RESULTS : TAB_SPACES;
  localparam logic [sgr_pkg::CNT_W-1:0] TAB_N = sgr_pkg::CNT_W'(TAB_CAP);
  localparam logic [sgr_pkg::CNT_W-1:0] ONE_N = sgr_pkg::CNT_W'(1);

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  // apply one sgr code to an attribute set
  function automatic sgr_pkg::attr_t apply_code(sgr_pkg::attr_t a, logic [7:0] code);
    sgr_pkg::attr_t r;
    logic [7:0]     d;
    r = a;
    d = 8'd0;
    if (code inside {[SGR_FG_LO:SGR_FG_HI]}) begin
      d = code - SGR_FG_LO;
      r.fg_valid = 1'b1;
      r.fg_index = d[3:0];
    end else if (code inside {[SGR_FGB_LO:SGR_FGB_HI]}) begin
      d = code - SGR_FGB_BASE;
      r.fg_valid = 1'b1;
      r.fg_index = d[3:0];
    end else if (code inside {[SGR_BG_LO:SGR_BG_HI]}) begin
      d = code - SGR_BG_LO;
      r.bg_valid = 1'b1;
      r.bg_index = d[3:0];
    end else if (code inside {[SGR_BGB_LO:SGR_BGB_HI]}) begin
      d = code - SGR_BGB_BASE;
      r.bg_valid = 1'b1;
      r.bg_index = d[3:0];
    end else begin
      case (code)
        SGR_RESET:     r = '0;
        SGR_BOLD:      r.weight = WT_BOLD;
        SGR_LIGHT:     r.weight = WT_LIGHT;
        SGR_ITALIC:    r.italic_on = 1'b1;
        SGR_UNDER:     r.underline_on = 1'b1;
        SGR_SWAP: begin
          // both sides read the old values
          if (a.fg_valid) begin
            r.bg_valid = 1'b1;
            r.bg_index = a.fg_index;
          end
          if (a.bg_valid) begin
            r.fg_valid = 1'b1;
            r.fg_index = a.bg_index;
          end
        end
        SGR_STRIKE:    r.strike_on = 1'b1;
        SGR_NORMAL:    r.weight = WT_NORMAL;
        SGR_NO_ITALIC: r.italic_on = 1'b0;
        SGR_NO_UNDER:  r.underline_on = 1'b0;
        SGR_NO_STRIKE: r.strike_on = 1'b0;
        default:       r = a;
      endcase
    end
    return r;
  endfunction

  phase_t         phase_r, phase_nxt;
  logic [7:0]     accum_r, accum_nxt;
  logic           nonempty_r, nonempty_nxt;
  logic           bad_r, bad_nxt;
  logic           any_r, any_nxt;
  sgr_pkg::attr_t pend_r, pend_nxt;
  sgr_pkg::attr_t active_r, active_nxt;

  sgr_pkg::attr_t closed;
  logic [11:0]    prod;
  logic           text_path;

  // segment close and decimal accumulate
  always_comb begin
    closed = (nonempty_r && !bad_r) ? apply_code(pend_r, accum_r) : pend_r;
    prod   = 12'(accum_r) * 12'd10 + 12'(byte_in[3:0]);
  end

  // next state and emitted words
  always_comb begin
    phase_nxt      = phase_r;
    accum_nxt      = accum_r;
    nonempty_nxt   = nonempty_r;
    bad_nxt        = bad_r;
    any_nxt        = any_r;
    pend_nxt       = pend_r;
    active_nxt     = active_r;
    emit.count     = '0;
    emit.char_code = byte_in;
    text_path      = 1'b0;

    case (phase_r)
      PH_ESC: begin
        if (byte_in == CH_LBRACKET) begin
          phase_nxt    = PH_CSI;
          accum_nxt    = 8'd0;
          nonempty_nxt = 1'b0;
          bad_nxt      = 1'b0;
          any_nxt      = 1'b0;
          pend_nxt     = active_r;
        end else begin
          text_path = 1'b1;
        end
      end
      PH_CSI: begin
        if (byte_in inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
          if (byte_in == CH_M) begin
            active_nxt = any_r ? closed : '0;
          end
          phase_nxt    = PH_TEXT;
          accum_nxt    = 8'd0;
          nonempty_nxt = 1'b0;
          bad_nxt      = 1'b0;
          any_nxt      = 1'b0;
        end else if (byte_in == CH_SEMI) begin
          pend_nxt     = closed;
          accum_nxt    = 8'd0;
          nonempty_nxt = 1'b0;
          bad_nxt      = 1'b0;
        end else begin
          nonempty_nxt = 1'b1;
          any_nxt      = 1'b1;
          if (byte_in inside {[CH_ZERO:CH_NINE]}) begin
            accum_nxt = (prod > 12'd255) ? 8'hFF : prod[7:0];
          end else begin
            bad_nxt = 1'b1;
          end
        end
      end
      default: text_path = 1'b1;
    endcase

    // ground state byte handling
    if (text_path) begin
      phase_nxt = PH_TEXT;
      if (byte_in == CH_ESC) begin
        phase_nxt = PH_ESC;
      end else if (byte_in == CH_CR || byte_in == CH_BEL) begin
        emit.count = '0;
      end else if (byte_in == CH_TAB) begin
        emit.count     = TAB_N;
        emit.char_code = CH_SPACE;
      end else begin
        emit.count = ONE_N;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TEXT;
      accum_r    <= 8'd0;
      nonempty_r <= 1'b0;
      bad_r      <= 1'b0;
      any_r      <= 1'b0;
      pend_r     <= '0;
      active_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      nonempty_r <= nonempty_nxt;
      bad_r      <= bad_nxt;
      any_r      <= any_nxt;
      pend_r     <= pend_nxt;
      active_r   <= active_nxt;
    end
  end

  assign active = active_r;

endmodule

>>> hw/rtl/ansi_sgr_stream_parser_core.sv
// top level of the ansi sgr stream parser
//
// Takes a terminal byte stream on in_ch and gives text words on out_ch, each
// tagged with the attributes (weight, italic, underline, strike, colours) set
// by the ESC [ ... m sequences seen before it. Both channels are valid/ready;
// a word moves at a rising edge where both are high.
// A byte taken from in_ch sits in the input register, is parsed from there into
// the result register, and its first word is on out_ch from that register.
// Throughput: one byte per cycle while out_ch is ready and each byte gives at
// most one word. A text byte gives one word, a tab gives TAB_SPACES space
// words (at most four), one per cycle while out_ch is ready; bytes of an
// escape sequence, CR, BEL and a lone ESC give none. last_of_run marks the
// final word of each byte. The rate is set by the single result register.
// When out_ch stalls, bytes that give no words still pass the parser; a byte
// that gives words waits in the input register, and in_ch ready drops once
// that register is full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to plain text with default attributes.
module ansi_sgr_stream_parser_core #(
  parameter int TAB_SPACES = 4
) (
  input logic        clk,
  input logic        rst_n,
  sgr_in_if.sink     in_ch,
  sgr_out_if.source  out_ch
);

  localparam logic [sgr_pkg::CNT_W-1:0] ONE_N = sgr_pkg::CNT_W'(1);

  logic                      a_valid_r;
  logic [7:0]                a_byte_r;
  logic [sgr_pkg::CNT_W-1:0] b_cnt_r;
  logic [7:0]                b_char_r;
  sgr_pkg::attr_t            b_attr_r;

  sgr_pkg::emit_t emit;
  sgr_pkg::attr_t active;
  logic           b_free;
  logic           a_adv;
  logic           in_take;
  logic           out_take;

  sgr_parse #(
    .TAB_SPACES (TAB_SPACES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (a_adv),
    .byte_in (a_byte_r),
    .emit    (emit),
    .active  (active)
  );

  // handshake control
  always_comb begin
    out_take = out_ch.valid && out_ch.ready;
    b_free   = (b_cnt_r == '0) || (out_ch.ready && b_cnt_r == ONE_N);
    a_adv    = a_valid_r && ((emit.count == '0) || b_free);
    in_take  = in_ch.valid && in_ch.ready;
  end

  assign in_ch.ready = !a_valid_r || a_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r <= in_ch.in_byte;
    end
  end

  // result register with remaining word count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cnt_r <= '0;
    end else if (a_adv && emit.count != '0) begin
      b_cnt_r <= emit.count;
    end else if (out_take) begin
      b_cnt_r <= b_cnt_r - ONE_N;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && emit.count != '0) begin
      b_char_r <= emit.char_code;
      b_attr_r <= active;
    end
  end

  // result word
  always_comb begin
    out_ch.valid        = (b_cnt_r != '0);
    out_ch.char_code    = b_char_r;
    out_ch.weight       = b_attr_r.weight;
    out_ch.italic_on    = b_attr_r.italic_on;
    out_ch.underline_on = b_attr_r.underline_on;
    out_ch.strike_on    = b_attr_r.strike_on;
    out_ch.fg_valid     = b_attr_r.fg_valid;
    out_ch.fg_index     = b_attr_r.fg_valid ? b_attr_r.fg_index : 4'd0;
    out_ch.bg_valid     = b_attr_r.bg_valid;
    out_ch.bg_index     = b_attr_r.bg_valid ? b_attr_r.bg_index : 4'd0;
    out_ch.last_of_run  = (b_cnt_r == ONE_N);
  end

endmodule
